[hw/rtl/dsfb_pkg.sv]
// Shared widths, constants, the request struct and the segment table of the frame builder.
`timescale 1ns / 1ps

package dsfb_pkg;

	// Field widths
	localparam int NUMBER_W  = 27;
	localparam int POINT_W   = 4;
	localparam int REG_W     = 4;
	localparam int SEG_W     = 8;
	localparam int DIGIT_W   = 4;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	// Default number of digits in one frame
	localparam int DIGIT_COUNT_DEF = 8;

	// Divide by ten: q = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^32
	localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Decimal point segment
	localparam logic [SEG_W-1:0] POINT_BIT = 8'b1000_0000;

	// One register-write request toward the display
	typedef struct packed {
		logic [REG_W-1:0] digit_register;
		logic [SEG_W-1:0] segment_pattern;
		logic             last;
	} dsfb_result_t;

	// Map a decimal digit to its segment pattern
	function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] pattern;
		case (digit)
			4'd0: pattern = 8'b0111_1110;
			4'd1: pattern = 8'b0011_0000;
			4'd2: pattern = 8'b0110_1101;
			4'd3: pattern = 8'b0111_1001;
			4'd4: pattern = 8'b0011_0011;
			4'd5: pattern = 8'b0101_1011;
			4'd6: pattern = 8'b0101_1111;
			4'd7: pattern = 8'b0111_0000;
			4'd8: pattern = 8'b0111_1111;
			4'd9: pattern = 8'b0111_1011;
			default: pattern = 8'b0000_0000;
		endcase
		return pattern;
	endfunction

endpackage

[hw/rtl/dsfb_digit_step.sv]
// One digit step: split off the low decimal digit and build its write request.
`timescale 1ns / 1ps

module dsfb_digit_step #(
	parameter int DIGIT_COUNT = dsfb_pkg::DIGIT_COUNT_DEF,
	parameter int IDX_W       = 3
) (
	input  logic [dsfb_pkg::NUMBER_W-1:0] value,
	input  logic [dsfb_pkg::POINT_W-1:0]  point,
	input  logic [IDX_W-1:0]              idx,
	output logic [dsfb_pkg::NUMBER_W-1:0] next_value,
	output logic [dsfb_pkg::DIGIT_W-1:0]  digit,
	output dsfb_pkg::dsfb_result_t        result
);
	import dsfb_pkg::*;

	localparam int PROD_W = NUMBER_W + 32;
	localparam int QUOT_W = NUMBER_W - 3;

	logic [PROD_W-1:0]   prod;
	logic [QUOT_W-1:0]   quot;
	logic [NUMBER_W-1:0] times_ten;
	logic [NUMBER_W-1:0] rem_full;
	logic [SEG_W-1:0]    pattern;

	// Divide by ten through the reciprocal
	assign prod       = PROD_W'(value) * PROD_W'(RECIP);
	assign quot       = prod[RECIP_SHIFT +: QUOT_W];
	assign next_value = NUMBER_W'(quot);

	// Remainder is value minus 8q + 2q
	assign times_ten = NUMBER_W'({quot, 3'b000}) + NUMBER_W'({quot, 1'b0});
	assign rem_full  = value - times_ten;
	assign digit     = rem_full[DIGIT_W-1:0];

	// Look up segments, add the point on the matching digit
	always_comb begin
		pattern = seg_lookup(digit);
		if (point == POINT_W'(idx)) begin
			pattern = pattern | POINT_BIT;
		end
	end

	assign result.digit_register  = REG_W'(idx) + REG_W'(1);
	assign result.segment_pattern = pattern;
	assign result.last            = (idx == IDX_W'(DIGIT_COUNT - 1));

endmodule

[hw/rtl/dsfb_digit_engine.sv]
// Working register and digit counter: one digit per ready cycle from the held number.
`timescale 1ns / 1ps

module dsfb_digit_engine #(
	parameter int DIGIT_COUNT = dsfb_pkg::DIGIT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_take,
	input  logic [dsfb_pkg::NUMBER_W-1:0] in_number,
	input  logic [dsfb_pkg::POINT_W-1:0]  in_point,
	input  logic                          out_ready,
	output logic                          out_fire,
	output dsfb_pkg::dsfb_result_t        out_result
);
	import dsfb_pkg::*;

	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic                busy_q;
	logic [NUMBER_W-1:0] value_q;
	logic [POINT_W-1:0]  point_q;
	logic [IDX_W-1:0]    idx_q;
	logic [NUMBER_W-1:0] next_value;
	logic [DIGIT_W-1:0]  digit;
	dsfb_result_t        result;
	logic                free;

	dsfb_digit_step #(
		.DIGIT_COUNT(DIGIT_COUNT),
		.IDX_W      (IDX_W)
	) u_step (
		.value     (value_q),
		.point     (point_q),
		.idx       (idx_q),
		.next_value(next_value),
		.digit     (digit),
		.result    (result)
	);

	// Emit a digit whenever the result register can take it
	assign out_fire   = busy_q && out_ready;
	assign out_result = result;

	// Free when idle or as the last digit leaves, so the next number follows at once
	assign free    = !busy_q || (out_fire && result.last);
	assign in_take = in_valid && free;

	// Load a new number or advance to the next digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (result.last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Hold the working value and point
	always_ff @(posedge clk) begin
		if (in_take) begin
			value_q <= in_number;
			point_q <= in_point;
		end else if (out_fire) begin
			value_q <= next_value;
		end
	end

	// A new number enters only when idle or on the last digit
	a_load_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && busy_q) |-> (out_fire && result.last))
		else $error("number loaded while digits still pending");

	// Digit counter stays inside the frame
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= IDX_W'(DIGIT_COUNT - 1)))
		else $error("digit index past frame end");

	// Reciprocal division always leaves a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (digit <= DIGIT_W'(9)))
		else $error("remainder not a decimal digit");

	// Last digit with nothing waiting leaves the engine idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && result.last && !in_valid) |=> !busy_q)
		else $error("engine still busy after last digit");

endmodule

[hw/rtl/decimal_seven_segment_frame_builder.sv]
// A request accepted into the input register passes the digit engine's working register
// and the result register before its first digit write. Throughput: DIGIT_COUNT writes
// per request (8 by default), one digit write per cycle unless m_axis_tready stalls, set
// by the single divide-by-ten step in the digit engine; the next request is taken while
// the current one is still being split. Reset: arst_n clears all valid flags and the
// digit counter asynchronously; data registers are not reset.
`timescale 1ns / 1ps

module decimal_seven_segment_frame_builder #(
	parameter int DIGIT_COUNT = dsfb_pkg::DIGIT_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [26:0] number, [30:27] point_position, [31] zero
	input  logic [dsfb_pkg::S_TDATA_W-1:0] s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] digit_register, [11:4] segment_pattern, [15:12] zero
	output logic [dsfb_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);
	import dsfb_pkg::*;

	logic                valid_s1;
	logic [NUMBER_W-1:0] number_s1;
	logic [POINT_W-1:0]  point_s1;
	logic                eng_take;
	logic                eng_fire;
	logic                out_ready;
	dsfb_result_t        eng_result;
	logic                m_valid_q;
	dsfb_result_t        m_result_q;

	// Input register: take a request when empty or when the engine takes the held one
	assign s_axis_tready = !valid_s1 || eng_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			number_s1 <= s_axis_tdata[NUMBER_W-1:0];
			point_s1  <= s_axis_tdata[NUMBER_W +: POINT_W];
		end
	end

	dsfb_digit_engine #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_take   (eng_take),
		.in_number (number_s1),
		.in_point  (point_s1),
		.out_ready (out_ready),
		.out_fire  (eng_fire),
		.out_result(eng_result)
	);

	// Result register: refill when empty or when the downstream takes it
	assign out_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ready) begin
			m_valid_q <= eng_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_fire) begin
			m_result_q <= eng_result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = M_TDATA_W'({m_result_q.segment_pattern, m_result_q.digit_register});
	assign m_axis_tlast  = m_result_q.last;

endmodule
